FILE: rtl/eiagm_pkg.sv
// eiagm_pkg: constants, widths and the arctangent table for the elliptic integral core
// self-contained; imported by elliptic_integral_first_kind_agm_core
`default_nettype none

package eiagm_pkg;

    localparam int MAX_ITERATIONS = 8;
    localparam int CORDIC_STEPS   = 32;

    localparam int N_W    = $clog2(MAX_ITERATIONS + 1);
    localparam int K_W    = MAX_ITERATIONS - 1;
    localparam int CIDX_W = $clog2(CORDIC_STEPS);
    localparam int PHI_W  = 64 + K_W;
    localparam int CNT_W  = 7;

    localparam logic [63:0] ONE_Q60     = 64'd1 << 60;
    localparam logic [31:0] ONE_Q30     = 32'd1 << 30;
    localparam logic [31:0] LN2_Q30     = 32'd744261118;
    localparam logic [31:0] TOL_RESET   = 32'd4096;
    localparam logic [63:0] NORM_HI     = 64'd1 << 60;
    localparam logic [63:0] NORM_LO     = 64'd1 << 59;
    localparam logic [63:0] COT_NUM     = 64'd1 << 46;
    localparam logic [63:0] SQRT_BIT0   = 64'd1 << 62;
    localparam logic [64:0] ASINH_LIMIT = 65'd1 << 31;
    localparam logic [6:0]  LN_TERMS    = 7'd64;
    localparam logic [6:0]  MANT_POS    = 7'd30;
    localparam logic [5:0]  ASINH_EBASE = 6'd16;
    localparam logic [6:0]  ASINH_SH0   = 7'd15;

    // series ratio selection for table build
    localparam int SER_FIVE = 0;
    localparam int SER_239  = 1;
    localparam int SER_POW  = 2;
    localparam int SERIES_LEN = 64;

    typedef logic [CORDIC_STEPS-1:0][63:0] atan_rom_t;

    function automatic logic [63:0] odd_div(input logic [63:0] t, input int n);
        logic [63:0] r;
        case (n)
            0:  r = t;
            1:  r = t / 3;
            2:  r = t / 5;
            3:  r = t / 7;
            4:  r = t / 9;
            5:  r = t / 11;
            6:  r = t / 13;
            7:  r = t / 15;
            8:  r = t / 17;
            9:  r = t / 19;
            10: r = t / 21;
            11: r = t / 23;
            12: r = t / 25;
            13: r = t / 27;
            14: r = t / 29;
            15: r = t / 31;
            16: r = t / 33;
            17: r = t / 35;
            18: r = t / 37;
            19: r = t / 39;
            20: r = t / 41;
            21: r = t / 43;
            22: r = t / 45;
            23: r = t / 47;
            24: r = t / 49;
            25: r = t / 51;
            26: r = t / 53;
            27: r = t / 55;
            28: r = t / 57;
            29: r = t / 59;
            30: r = t / 61;
            31: r = t / 63;
            default: r = '0;
        endcase
        return r;
    endfunction

    // alternating arctangent series, elaboration time only
    function automatic logic [63:0] alt_series(input logic [63:0] first, input int mode,
                                               input int sh);
        logic [63:0] sum;
        logic [63:0] t;
        sum = '0;
        t   = first;
        for (int n = 0; n < SERIES_LEN; n++) begin
            if (t != 0) begin
                if (n[0])
                    sum = sum - odd_div(t, n);
                else
                    sum = sum + odd_div(t, n);
                case (mode)
                    SER_FIVE: t = t / 25;
                    SER_239:  t = t / 57121;
                    default:  t = (sh < 64) ? (t >> sh) : '0;
                endcase
            end
        end
        return sum;
    endfunction

    function automatic atan_rom_t build_atan_rom();
        atan_rom_t   rom;
        logic [63:0] a5;
        logic [63:0] a239;
        a5     = alt_series(ONE_Q60 / 5, SER_FIVE, 0);
        a239   = alt_series(ONE_Q60 / 239, SER_239, 0);
        rom[0] = (a5 << 2) - a239;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            rom[i] = alt_series((i <= 60) ? (ONE_Q60 >> i) : 64'd0, SER_POW, 2 * i);
        end
        return rom;
    endfunction

    localparam atan_rom_t   ATAN_ROM    = build_atan_rom();
    localparam logic [63:0] PI_Q60      = ATAN_ROM[0] << 2;
    localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;

endpackage

`default_nettype wire

FILE: rtl/elliptic_integral_first_kind_agm_core.sv
// incomplete elliptic integral of the first kind, agm iteration on shared serial units
// depends on eiagm_pkg (constants, arctangent table)
//
// usage
//   item channel (item_valid / item_ready) takes one beat: amplitude_tangent (Q16.16)
//   and complementary_modulus (Q2.30). result channel (result_valid / result_ready)
//   gives one beat per item: integral_value (Q8.24, saturated) and overflow_flag.
//   relative_tolerance is written through config_write_enable / config_write_data;
//   write it only while the core is idle (the core does not enforce it); reset value 4096.
// sequence
//   item_ready is high only while the sequencer is idle. one item runs the cotangent
//   divide, then per mean iteration a bit-serial divide and a bit-serial square root,
//   then the normalising shifts, CORDIC_STEPS rotation steps and a final divide.
//   the asinh path (kc zero) is dominated by the log series, one divide per term.
//   x zero goes straight to the finish.
// reset and stall
//   rst_n clears the sequencer, the result valid and loads the tolerance reset value.
//   a finished result sits in the output register; the next item is taken while it
//   waits, but that item's result holds in the sequencer until the beat is taken.
`default_nettype none

module elliptic_integral_first_kind_agm_core
    import eiagm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               config_write_enable,
    input  wire logic [31:0]        config_write_data,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic signed [31:0] amplitude_tangent,
    input  wire logic signed [31:0] complementary_modulus,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic signed [31:0]      integral_value,
    output logic                    overflow_flag
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_DIV, S_SQRT,
        S_AG_INIT, S_AG_MUL, S_AG_TOL, S_AG_DIVGO, S_AG_CM, S_AG_NEXT,
        S_CO_NORM, S_CO_ROT, S_CO_CLAMP, S_PHI_ACC, S_PHI_SUM, S_AG_DONE,
        S_AS_SH, S_AS_MUL, S_AS_SQ, S_AS_U, S_AS_BP, S_AS_M,
        S_LN_Z, S_LN_Z2, S_LN_Z2B, S_LN_LOOP, S_LN_ACC, S_LN_T,
        S_AS_R, S_AS_FIN, S_FINISH
    } state_t;

    // control
    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        tol_reg, tol_next;

    // datapath
    logic               xneg_reg, xneg_next;
    logic [31:0]        xmag_reg, xmag_next;
    logic [31:0]        kmag_reg, kmag_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        g_reg, g_next;
    logic [63:0]        cm_reg, cm_next;
    logic               cneg_reg, cneg_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic               conv_reg, conv_next;
    logic [63:0]        p_reg, p_next;
    logic [63:0]        t_reg, t_next;
    logic [63:0]        sum_reg, sum_next;
    logic [63:0]        mag_reg, mag_next;
    logic [63:0]        dnum_reg, dnum_next;
    logic [63:0]        dden_reg, dden_next;
    logic [63:0]        drem_reg, drem_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic [63:0]        sv_reg, sv_next;
    logic [63:0]        sres_reg, sres_next;
    logic [63:0]        sbit_reg, sbit_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [5:0]         e_reg, e_next;
    logic signed [63:0] cx_reg, cx_next;
    logic signed [63:0] cy_reg, cy_next;
    logic signed [63:0] cz_reg, cz_next;
    logic [PHI_W-1:0]   phi_reg, phi_next;
    logic [31:0]        value_reg, value_next;
    logic               flag_reg, flag_next;

    // shared units and helpers
    logic [31:0]        mul_x, mul_y;
    logic [63:0]        mul_prod;
    logic [64:0]        rem_sh, rem_sub;
    logic               div_ge;
    logic [63:0]        sq_try;
    logic               sq_ge;
    logic [32:0]        ag_sum;
    logic [31:0]        ag_diff;
    logic               cm_ge;
    logic [63:0]        cm_d, cm_h;
    logic [CIDX_W-1:0]  co_idx;
    logic signed [63:0] co_dx, co_dy, co_rom;
    logic [63:0]        co_mx;
    logic [63:0]        theta;
    logic [46:0]        as_shx;
    logic [63:0]        as_m;
    logic [6:0]         e_ext;
    logic [PHI_W-1:0]   phi_full, phi_sh;
    logic [N_W:0]       n_inc;
    logic [31:0]        sat_mag;

    logic               accept;

    assign item_ready     = (state_reg == S_IDLE);
    assign accept         = item_valid && item_ready;
    assign result_valid   = out_valid_reg;
    assign integral_value = value_reg;
    assign overflow_flag  = flag_reg;

    // one 32x32 multiplier, operands chosen by the sequencer
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            S_AG_MUL:
            begin
                mul_x = a_reg;
                mul_y = g_reg;
            end
            S_AG_TOL:
            begin
                mul_x = a_reg;
                mul_y = tol_reg;
            end
            S_AS_MUL:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            S_LN_Z2:
            begin
                mul_x = dnum_reg[31:0];
                mul_y = dnum_reg[31:0];
            end
            S_LN_ACC:
            begin
                mul_x = t_reg[31:0];
                mul_y = g_reg;
            end
            S_AS_R:
            begin
                mul_x = {26'd0, e_reg};
                mul_y = LN2_Q30;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_prod = 64'(mul_x) * 64'(mul_y);

    // restoring divider step
    assign rem_sh  = {drem_reg, dnum_reg[63]};
    assign rem_sub = rem_sh - {1'b0, dden_reg};
    assign div_ge  = (rem_sh >= {1'b0, dden_reg});

    // square root step
    assign sq_try = sres_reg + sbit_reg;
    assign sq_ge  = (sv_reg >= sq_try);

    // mean iteration
    assign ag_sum  = {1'b0, a_reg} + {1'b0, g_reg};
    assign ag_diff = (a_reg >= g_reg) ? (a_reg - g_reg) : (g_reg - a_reg);
    assign cm_ge   = (cm_reg >= dnum_reg);
    assign cm_d    = cm_ge ? (cm_reg - dnum_reg) : (dnum_reg - cm_reg);
    assign cm_h    = cm_d >> 1;
    assign n_inc   = {1'b0, n_reg} + 1'b1;

    // cordic rotation
    assign co_idx = cnt_reg[CIDX_W-1:0];
    assign co_dx  = cy_reg >>> co_idx;
    assign co_dy  = cx_reg >>> co_idx;
    assign co_rom = $signed(ATAN_ROM[co_idx]);
    assign co_mx  = ($unsigned(cx_reg) > $unsigned(cy_reg)) ? $unsigned(cx_reg)
                                                             : $unsigned(cy_reg);

    always_comb
    begin
        if (cz_reg[63])
            theta = '0;
        else if ($unsigned(cz_reg) > HALF_PI_Q60)
            theta = HALF_PI_Q60;
        else
            theta = $unsigned(cz_reg);
        if (cneg_reg)
            theta = PI_Q60 - theta;
    end

    assign phi_full = phi_reg + PHI_W'(t_reg);
    assign phi_sh   = phi_full >> n_reg;

    // asinh path helpers
    assign as_shx = {15'd0, xmag_reg} << cnt_reg[3:0];
    assign as_m   = (cnt_reg >= MANT_POS) ? (t_reg >> (cnt_reg - MANT_POS))
                                          : (t_reg << (MANT_POS - cnt_reg));
    assign e_ext  = {1'b0, e_reg};

    assign sat_mag = (mag_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_reg[31:0];

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg;
        tol_next       = tol_reg;
        xneg_next      = xneg_reg;
        xmag_next      = xmag_reg;
        kmag_next      = kmag_reg;
        a_next         = a_reg;
        g_next         = g_reg;
        cm_next        = cm_reg;
        cneg_next      = cneg_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        conv_next      = conv_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        sum_next       = sum_reg;
        mag_next       = mag_reg;
        dnum_next      = dnum_reg;
        dden_next      = dden_reg;
        drem_next      = drem_reg;
        dcnt_next      = dcnt_reg;
        sv_next        = sv_reg;
        sres_next      = sres_reg;
        sbit_next      = sbit_reg;
        cnt_next       = cnt_reg;
        e_next         = e_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        phi_next       = phi_reg;
        value_next     = value_reg;
        flag_next      = flag_reg;

        if (config_write_enable)
            tol_next = config_write_data;

        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    xneg_next  = amplitude_tangent[31];
                    xmag_next  = amplitude_tangent[31] ? (~amplitude_tangent + 32'd1)
                                                       : amplitude_tangent;
                    kmag_next  = complementary_modulus[31] ? (~complementary_modulus + 32'd1)
                                                           : complementary_modulus;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (xmag_reg == 0)
                begin
                    mag_next   = '0;
                    state_next = S_FINISH;
                end
                else if (kmag_reg == 0)
                begin
                    cnt_next   = ASINH_SH0;
                    state_next = S_AS_SH;
                end
                else
                begin
                    dnum_next  = COT_NUM;
                    dden_next  = 64'(xmag_reg);
                    drem_next  = '0;
                    dcnt_next  = '0;
                    ret_next   = S_AG_INIT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                dnum_next = {dnum_reg[62:0], div_ge};
                drem_next = div_ge ? rem_sub[63:0] : rem_sh[63:0];
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                    state_next = ret_reg;
            end
            S_SQRT:
            begin
                if (sq_ge)
                begin
                    sv_next   = sv_reg - sq_try;
                    sres_next = (sres_reg >> 1) + sbit_reg;
                end
                else
                    sres_next = sres_reg >> 1;
                sbit_next = sbit_reg >> 2;
                if (sbit_reg[0])
                    state_next = ret_reg;
            end
            S_AG_INIT:
            begin
                cm_next    = dnum_reg;
                a_next     = ONE_Q30;
                g_next     = kmag_reg;
                cneg_next  = 1'b0;
                k_next     = '0;
                n_next     = '0;
                state_next = S_AG_MUL;
            end
            S_AG_MUL:
            begin
                p_next     = mul_prod;
                state_next = S_AG_TOL;
            end
            S_AG_TOL:
            begin
                t_next     = mul_prod;
                state_next = S_AG_DIVGO;
            end
            S_AG_DIVGO:
            begin
                conv_next  = ({ag_diff, 32'd0} <= t_reg);
                dnum_next  = p_reg;
                dden_next  = cm_reg;
                drem_next  = '0;
                dcnt_next  = '0;
                ret_next   = S_AG_CM;
                state_next = S_DIV;
            end
            S_AG_CM:
            begin
                // a zero cotangent becomes one lsb of positive sign
                if (cm_h == 0)
                begin
                    cm_next   = 64'd1;
                    cneg_next = 1'b0;
                end
                else
                begin
                    cm_next   = cm_h;
                    cneg_next = cneg_reg ^ !cm_ge;
                end
                sv_next    = p_reg;
                sres_next  = '0;
                sbit_next  = SQRT_BIT0;
                ret_next   = S_AG_NEXT;
                state_next = S_SQRT;
            end
            S_AG_NEXT:
            begin
                a_next = ag_sum[32:1];
                n_next = n_inc[N_W-1:0];
                if (conv_reg || (n_inc >= (N_W+1)'(MAX_ITERATIONS)))
                begin
                    cx_next    = $signed(cm_reg);
                    cy_next    = $signed(64'(ag_sum[32:1]));
                    state_next = S_CO_NORM;
                end
                else
                begin
                    g_next     = sres_reg[31:0];
                    k_next     = {k_reg[K_W-2:0], cneg_reg};
                    state_next = S_AG_MUL;
                end
            end
            S_CO_NORM:
            begin
                if (co_mx == 0)
                begin
                    cz_next    = '0;
                    state_next = S_CO_CLAMP;
                end
                else if (co_mx >= NORM_HI)
                begin
                    cx_next = cx_reg >>> 1;
                    cy_next = cy_reg >>> 1;
                end
                else if (co_mx < NORM_LO)
                begin
                    cx_next = cx_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                end
                else
                begin
                    cnt_next   = '0;
                    cz_next    = '0;
                    state_next = S_CO_ROT;
                end
            end
            S_CO_ROT:
            begin
                if (!cy_reg[63])
                begin
                    cx_next = cx_reg + co_dx;
                    cy_next = cy_reg - co_dy;
                    cz_next = cz_reg + co_rom;
                end
                else
                begin
                    cx_next = cx_reg - co_dx;
                    cy_next = cy_reg + co_dy;
                    cz_next = cz_reg - co_rom;
                end
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = S_CO_CLAMP;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_CO_CLAMP:
            begin
                t_next     = theta;
                phi_next   = '0;
                cnt_next   = '0;
                state_next = S_PHI_ACC;
            end
            S_PHI_ACC:
            begin
                // quadrant count times pi, msb first shift and add
                phi_next = (phi_reg << 1) + (k_reg[K_W-1] ? PHI_W'(PI_Q60) : '0);
                k_next   = k_reg << 1;
                if (cnt_reg == CNT_W'(K_W - 1))
                    state_next = S_PHI_SUM;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_PHI_SUM:
            begin
                dnum_next  = phi_sh[63:0];
                dden_next  = (a_reg == 0) ? 64'd1 : {26'd0, a_reg, 6'd0};
                drem_next  = '0;
                dcnt_next  = '0;
                ret_next   = S_AG_DONE;
                state_next = S_DIV;
            end
            S_AG_DONE:
            begin
                mag_next   = dnum_reg;
                state_next = S_FINISH;
            end
            S_AS_SH:
            begin
                if ((cnt_reg[3:0] != 0) && ({18'd0, as_shx} > ASINH_LIMIT))
                    cnt_next = cnt_reg - 1'b1;
                else
                begin
                    a_next     = as_shx[31:0];
                    e_next     = ASINH_EBASE + {2'd0, cnt_reg[3:0]};
                    state_next = S_AS_MUL;
                end
            end
            S_AS_MUL:
            begin
                p_next     = mul_prod;
                state_next = S_AS_SQ;
            end
            S_AS_SQ:
            begin
                sv_next    = p_reg + (64'd1 << {e_reg, 1'b0});
                sres_next  = '0;
                sbit_next  = SQRT_BIT0;
                ret_next   = S_AS_U;
                state_next = S_SQRT;
            end
            S_AS_U:
            begin
                t_next     = 64'(a_reg) + sres_reg;
                sum_next   = 64'(a_reg) + sres_reg;
                cnt_next   = '0;
                state_next = S_AS_BP;
            end
            S_AS_BP:
            begin
                if (sum_reg[63:1] != 0)
                begin
                    sum_next = sum_reg >> 1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                    state_next = S_AS_M;
            end
            S_AS_M:
            begin
                a_next     = as_m[31:0];
                e_next     = (cnt_reg >= e_ext) ? 6'(cnt_reg - e_ext) : 6'd0;
                state_next = S_LN_Z;
            end
            S_LN_Z:
            begin
                dnum_next  = 64'(a_reg - ONE_Q30) << 30;
                dden_next  = 64'(a_reg) + 64'(ONE_Q30);
                drem_next  = '0;
                dcnt_next  = '0;
                ret_next   = S_LN_Z2;
                state_next = S_DIV;
            end
            S_LN_Z2:
            begin
                t_next     = dnum_reg;
                p_next     = mul_prod;
                state_next = S_LN_Z2B;
            end
            S_LN_Z2B:
            begin
                g_next     = p_reg[61:30];
                sum_next   = '0;
                cnt_next   = '0;
                state_next = S_LN_LOOP;
            end
            S_LN_LOOP:
            begin
                if ((t_reg == 0) || (cnt_reg == LN_TERMS))
                    state_next = S_AS_R;
                else
                begin
                    dnum_next  = t_reg;
                    dden_next  = 64'({cnt_reg, 1'b1});
                    drem_next  = '0;
                    dcnt_next  = '0;
                    ret_next   = S_LN_ACC;
                    state_next = S_DIV;
                end
            end
            S_LN_ACC:
            begin
                sum_next   = sum_reg + dnum_reg;
                p_next     = mul_prod;
                state_next = S_LN_T;
            end
            S_LN_T:
            begin
                t_next     = p_reg >> 30;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_LN_LOOP;
            end
            S_AS_R:
            begin
                p_next     = mul_prod;
                state_next = S_AS_FIN;
            end
            S_AS_FIN:
            begin
                mag_next   = (p_reg + (sum_reg << 1)) >> 6;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    flag_next      = (mag_reg > 64'h7FFF_FFFF);
                    value_next     = xneg_reg ? (32'd0 - sat_mag) : sat_mag;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            tol_reg       <= tol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xneg_reg  <= xneg_next;
        xmag_reg  <= xmag_next;
        kmag_reg  <= kmag_next;
        a_reg     <= a_next;
        g_reg     <= g_next;
        cm_reg    <= cm_next;
        cneg_reg  <= cneg_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
        conv_reg  <= conv_next;
        p_reg     <= p_next;
        t_reg     <= t_next;
        sum_reg   <= sum_next;
        mag_reg   <= mag_next;
        dnum_reg  <= dnum_next;
        dden_reg  <= dden_next;
        drem_reg  <= drem_next;
        dcnt_reg  <= dcnt_next;
        sv_reg    <= sv_next;
        sres_reg  <= sres_next;
        sbit_reg  <= sbit_next;
        cnt_reg   <= cnt_next;
        e_reg     <= e_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        phi_reg   <= phi_next;
        value_reg <= value_next;
        flag_reg  <= flag_next;
    end

endmodule

`default_nettype wire

FILE: test/elliptic_integral_first_kind_agm_core_tb.sv
// testbench for elliptic_integral_first_kind_agm_core: random and directed beats checked
// against a built-in fixed-point predictor of the agm elliptic integral; needs eiagm_pkg
`timescale 1ns / 100ps

module elliptic_integral_first_kind_agm_core_tb;
    import eiagm_pkg::*;

    typedef bit [63:0] u64;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] kc;
    } operand_t;

    typedef struct {
        logic signed [31:0] value;
        logic               flag;
    } integral_t;

    localparam u64 Q30 = u64'(1) << 30;
    localparam u64 Q60 = u64'(1) << 60;
    localparam u64 LN2 = u64'(744261118);

    logic               clk;
    logic               rst_n;
    logic               config_write_enable;
    logic [31:0]        config_write_data;
    logic               item_valid;
    logic               item_ready;
    logic signed [31:0] amplitude_tangent;
    logic signed [31:0] complementary_modulus;
    logic               result_valid;
    logic               result_ready;
    logic signed [31:0] integral_value;
    logic               overflow_flag;

    // predictor copies of the tolerance register and the angle table
    logic [31:0] tolerance_copy;
    u64          arctan_table [CORDIC_STEPS];
    u64          pi_q60_tb;

    operand_t  operand_queue [$];
    integral_t integral_queue [$];
    bit        beat_taken;
    bit        idling_on;
    int        send_gap;
    int        stall_left;
    int        errors;

    elliptic_integral_first_kind_agm_core i_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .config_write_enable   (config_write_enable),
        .config_write_data     (config_write_data),
        .item_valid            (item_valid),
        .item_ready            (item_ready),
        .amplitude_tangent     (amplitude_tangent),
        .complementary_modulus (complementary_modulus),
        .result_valid          (result_valid),
        .result_ready          (result_ready),
        .integral_value        (integral_value),
        .overflow_flag         (overflow_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // alternating arctangent power series, divisor sq between terms
    function automatic u64 arctan_series(input u64 first, input u64 sq);
        u64 sum;
        u64 t;
        u64 term;
        int n;
        sum = 0;
        t   = first;
        n   = 0;
        while (t != 0 && n < 64)
        begin
            term = t / u64'(2 * n + 1);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
            t = (sq == 0) ? u64'(0) : t / sq;
            n++;
        end
        return sum;
    endfunction

    function automatic void fill_arctan_table();
        u64 a5;
        u64 a239;
        a5   = arctan_series(Q60 / 5, 25);
        a239 = arctan_series(Q60 / 239, 57121);
        arctan_table[0] = 4 * a5 - a239;
        for (int i = 1; i < CORDIC_STEPS; i++)
            arctan_table[i] = arctan_series(Q60 >> i, u64'(1) << (2 * i));
        pi_q60_tb = 4 * arctan_table[0];
    endfunction

    function automatic u64 int_sqrt(input u64 v);
        u64 res;
        u64 b;
        res = 0;
        b   = u64'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // vectoring rotation, angle of (xi, yi) in Q60, clamped to [0, pi/2]
    function automatic u64 vector_angle(input u64 xi, input u64 yi);
        u64     mx;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        mx = (xi > yi) ? xi : yi;
        if (mx == 0)
            return 0;
        while (mx >= Q60)
        begin
            xi = xi >> 1;
            yi = yi >> 1;
            mx = mx >> 1;
        end
        while (mx < (Q60 >> 1))
        begin
            xi = xi << 1;
            yi = yi << 1;
            mx = mx << 1;
        end
        x = longint'(xi);
        y = longint'(yi);
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(arctan_table[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(arctan_table[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (u64'(z) > pi_q60_tb / 2)
            return pi_q60_tb / 2;
        return u64'(z);
    endfunction

    // natural log of a Q30 mantissa in [1, 2) via the atanh series
    function automatic u64 log_mantissa(input u64 m);
        u64 z;
        u64 z2;
        u64 t;
        u64 sum;
        int n;
        z   = ((m - Q30) << 30) / (m + Q30);
        z2  = (z * z) >> 30;
        t   = z;
        sum = 0;
        n   = 0;
        while (t != 0 && n < 64)
        begin
            sum = sum + t / u64'(2 * n + 1);
            t   = (t * z2) >> 30;
            n++;
        end
        return 2 * sum;
    endfunction

    // kc zero: asinh(|x|) in Q24
    function automatic u64 asinh_value(input u64 xm);
        int sh;
        int e;
        int bp;
        u64 xs;
        u64 s;
        u64 u;
        u64 m;
        u64 r;
        sh = 15;
        bp = 0;
        while (sh > 0 && (xm << sh) > (u64'(1) << 31))
            sh--;
        e  = 16 + sh;
        xs = xm << sh;
        s  = int_sqrt(xs * xs + (u64'(1) << (2 * e)));
        u  = xs + s;
        while (bp < 63 && (u >> (bp + 1)) != 0)
            bp++;
        m = (bp >= 30) ? (u >> (bp - 30)) : (u << (30 - bp));
        r = u64'((bp >= e) ? bp - e : 0) * LN2 + log_mantissa(m);
        return r >> 6;
    endfunction

    // mean iteration with quadrant tracking, Q24 magnitude
    function automatic u64 agm_value(input u64 xm, input u64 km, input logic [31:0] tol);
        u64 a;
        u64 g;
        u64 cm;
        u64 k;
        u64 p;
        u64 na;
        u64 q;
        u64 ng;
        u64 diff;
        u64 theta;
        u64 hi;
        u64 lo;
        u64 mask;
        u64 phi;
        u64 div;
        bit cneg;
        bit conv;
        int n;
        a    = Q30;
        g    = km;
        cm   = (u64'(1) << 46) / xm;
        k    = 0;
        cneg = 1'b0;
        n    = 0;
        while (1)
        begin
            p  = a * g;
            na = (a + g) >> 1;
            q  = p / cm;
            if (cm >= q)
                cm = cm - q;
            else
            begin
                cm   = q - cm;
                cneg = !cneg;
            end
            cm = cm >> 1;
            // cotangent collapsed to zero: nudge to one lsb
            if (cm == 0)
            begin
                cm   = 1;
                cneg = 1'b0;
            end
            ng   = int_sqrt(p);
            diff = (a > g) ? a - g : g - a;
            conv = (diff << 32) <= a * u64'(tol);
            a    = na;
            n++;
            if (conv || n >= MAX_ITERATIONS || n >= 62)
                break;
            g = ng;
            k = 2 * k + u64'(cneg);
        end
        theta = vector_angle(cm, a);
        if (cneg)
            theta = pi_q60_tb - theta;
        mask = (u64'(1) << n) - 1;
        hi   = k * (pi_q60_tb >> n) + (theta >> n);
        lo   = k * (pi_q60_tb & mask) + (theta & mask);
        phi  = hi + (lo >> n);
        div  = a << 6;
        if (div == 0)
            div = 1;
        return phi / div;
    endfunction

    function automatic integral_t predict_integral(input operand_t op, input logic [31:0] tol);
        integral_t r;
        bit        xneg;
        u64        xm;
        u64        km;
        u64        mag;
        xneg = op.x[31];
        xm   = xneg ? (u64'(1) << 32) - u64'(op.x[31:0]) : u64'(op.x[31:0]);
        km   = op.kc[31] ? (u64'(1) << 32) - u64'(op.kc[31:0]) : u64'(op.kc[31:0]);
        r.flag = 1'b0;
        if (xm == 0)
            mag = 0;
        else if (km == 0)
            mag = asinh_value(xm);
        else
            mag = agm_value(xm, km, tol);
        // saturate the magnitude before the sign goes on
        if (mag > 64'h7FFF_FFFF)
        begin
            mag    = 64'h7FFF_FFFF;
            r.flag = 1'b1;
        end
        r.value = xneg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // item driver: inputs change on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap   <= 0;
        end
        else if (!item_valid || beat_taken)
        begin
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                // start an idle burst
                item_valid <= 1'b0;
                send_gap   <= $urandom_range(0, 6);
            end
            else if (operand_queue.size() > 0)
            begin
                item_valid            <= 1'b1;
                amplitude_tangent     <= operand_queue[0].x;
                complementary_modulus <= operand_queue[0].kc;
                operand_queue.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result side back-pressure in random bursts of stalled cycles
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(0, 6);
        end
        else
            result_ready <= 1'b1;
    end

    // ---------------------------------------------------------------
    // monitor: both channels sampled on the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        operand_t  op;
        integral_t want;
        beat_taken = 1'b0;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                beat_taken = 1'b1;
                op.x  = amplitude_tangent;
                op.kc = complementary_modulus;
                integral_queue.push_back(predict_integral(op, tolerance_copy));
            end
            if (result_valid && result_ready)
            begin
                if (integral_queue.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %h flag %b",
                             $time, integral_value, overflow_flag);
                    errors++;
                end
                else
                begin
                    want = integral_queue.pop_front();
                    if (integral_value !== want.value)
                    begin
                        $display("%0t: integral_value expected %h actual %h",
                                 $time, want.value, integral_value);
                        errors++;
                    end
                    if (overflow_flag !== want.flag)
                    begin
                        $display("%0t: overflow_flag expected %b actual %b",
                                 $time, want.flag, overflow_flag);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic add_operand(input logic [31:0] x, input logic [31:0] kc);
        operand_t op;
        op.x  = x;
        op.kc = kc;
        operand_queue.push_back(op);
    endtask

    task automatic wait_drained();
        while (operand_queue.size() > 0 || item_valid || integral_queue.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [31:0] tol);
        config_write_enable <= 1'b1;
        config_write_data   <= tol;
        tolerance_copy      = tol;
        @(negedge clk);
        config_write_enable <= 1'b0;
    endtask

    // mostly sensible operands, with the odd corner mixed in
    task automatic add_random_operands(input int count);
        logic [31:0] x;
        logic [31:0] kc;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0:       x = $urandom;
                1:       x = $urandom >> $urandom_range(0, 31);
                2:       x = $urandom_range(0, 32'h0004_0000);
                default: x = $urandom >> $urandom_range(8, 31);
            endcase
            if ($urandom_range(0, 1))
                x = -x;
            if ($urandom_range(0, 40) == 0)
                x = 0;
            case ($urandom_range(0, 9))
                0:       kc = 0;
                1:       kc = 32'h8000_0000;
                2:       kc = 32'h4000_0000 + $urandom_range(0, 64) - 32;
                3, 4:    kc = $urandom;
                default: kc = $urandom_range(1, 32'h4000_0000);
            endcase
            if ($urandom_range(0, 3) == 0)
                kc = -kc;
            add_operand(x, kc);
        end
    endtask

    initial
    begin
        errors              = 0;
        idling_on           = 1'b1;
        beat_taken          = 1'b0;
        rst_n               = 1'b0;
        item_valid          = 1'b0;
        result_ready        = 1'b0;
        amplitude_tangent   = '0;
        complementary_modulus = '0;
        config_write_enable = 1'b0;
        config_write_data   = '0;
        tolerance_copy      = TOL_RESET;
        fill_arctan_table();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: zero x, asinh path, field extremes, negative kc
        add_operand(32'h0000_0000, 32'h4000_0000);
        add_operand(32'h0000_0000, 32'h0000_0000);
        add_operand(32'h0001_0000, 32'h4000_0000);
        add_operand(32'h0001_0000, 32'h0000_0000);
        add_operand(32'hFFFF_0000, 32'h0000_0000);
        add_operand(32'h7FFF_FFFF, 32'h0000_0000);
        add_operand(32'h8000_0000, 32'h0000_0000);
        add_operand(32'h0000_0001, 32'h0000_0000);
        add_operand(32'h0000_0001, 32'h4000_0000);
        add_operand(32'hFFFF_FFFF, 32'h4000_0000);
        add_operand(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_operand(32'h8000_0000, 32'h8000_0000);
        add_operand(32'h0001_0000, 32'h8000_0000);
        add_operand(32'h0001_0000, 32'hC000_0000);
        add_operand(32'h0001_0000, 32'h0000_0001);
        add_operand(32'h7FFF_FFFF, 32'h0000_0001);
        add_operand(32'h8000_0000, 32'h0000_0001);
        add_operand(32'h0010_0000, 32'h0000_0010);
        add_operand(32'h0000_8000, 32'h2000_0000);
        add_operand(32'hFFFF_8000, 32'hE000_0000);
        add_operand(32'h0003_0000, 32'h3FFF_FFFF);
        add_operand(32'h0000_0100, 32'h0000_0100);
        wait_drained();

        // no early stop: equal means or the iteration cap only
        write_tolerance(32'h0000_0000);
        add_operand(32'h0001_0000, 32'h4000_0000);
        add_operand(32'h0001_0000, 32'h0000_1000);
        add_random_operands(70);
        wait_drained();

        // loosest tolerance, stops after the first pass unless the means differ by a or more
        write_tolerance(32'hFFFF_FFFF);
        add_random_operands(70);
        wait_drained();

        write_tolerance($urandom);
        add_random_operands(70);
        wait_drained();

        write_tolerance(32'h0000_0001 << $urandom_range(0, 31));
        add_random_operands(70);
        wait_drained();

        // last stretch back at the reset value, no idling on either side
        write_tolerance(TOL_RESET);
        idling_on = 1'b0;
        add_random_operands(70);
        wait_drained();
        repeat (50) @(negedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
